FILE: rtl/hgpd_pkg.sv
// shared types, constants and helper functions of the holonomic goto-pose drive
package hgpd_pkg;

  localparam int CORDIC_STEPS_DEF        = 16;
  localparam int ANGLE_FRACTION_BITS_DEF = 12;

  localparam int POS_W       = 16;
  localparam int DIFF_W      = 17;
  localparam int SPEED_W     = 8;
  localparam int DIST_W      = 16;
  localparam int WHEEL_W     = 10;
  localparam int SQ_W        = 32;
  localparam int SUM_W       = 33;
  localparam int RAD_W       = 34;
  localparam int ROOT_W      = 17;
  localparam int REM_W       = 20;
  localparam int SQRT_STEPS  = 17;
  localparam int DIV_STEPS   = 8;
  localparam int DIV_BW      = 3;
  localparam int DIV_W       = 28;
  localparam int DEN_W       = 20;
  localparam int TNUM_W      = 26;
  localparam int PRE_SHIFT   = 14;
  localparam int CORDIC_W    = 34;
  localparam int VEC_W       = 33;
  localparam int Q30         = 30;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // 1/sqrt2 in Q30 split in two halves of the multiply
  localparam int                 INV_SQRT2_SPLIT = 15;
  localparam logic signed [15:0] INV_SQRT2_HI    = 16'sd23170;
  localparam logic signed [15:0] INV_SQRT2_LO    = 16'sd15565;

  // reciprocal multipliers for small constant divisions
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam logic [15:0] DIV100_MUL  = 16'd5243;
  localparam int          RECIP_SHIFT = 19;

  typedef enum logic [1:0] {
    BAND_FULL,
    BAND_PROP,
    BAND_CREEP,
    BAND_STOP
  } band_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_SPEED,
    REG_FAR_DISTANCE,
    REG_NEAR_DISTANCE,
    REG_STOP_DISTANCE,
    REG_FAST_TURN_ERROR,
    REG_SLOW_TURN_ERROR,
    REG_STOP_TURN_ERROR
  } reg_idx_t;

  typedef struct packed {
    logic [SPEED_W-1:0] max_speed;
    logic [DIST_W-1:0]  far_distance;
    logic [DIST_W-1:0]  near_distance;
    logic [DIST_W-1:0]  stop_distance;
    logic [DIST_W-1:0]  fast_turn_error;
    logic [DIST_W-1:0]  slow_turn_error;
    logic [DIST_W-1:0]  stop_turn_error;
  } cfg_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [SUM_W-1:0]         sum_sq;
    logic [TNUM_W-1:0]        turn_num;
    band_t                    dband;
    band_t                    tband;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [SPEED_W-1:0] div10(input logic [11:0] n);
    logic [27:0] p;
    p = 28'(n) * 28'(DIV10_MUL);
    return p[RECIP_SHIFT +: SPEED_W];
  endfunction

  function automatic logic [SPEED_W-1:0] div100(input logic [11:0] n);
    logic [27:0] p;
    p = 28'(n) * 28'(DIV100_MUL);
    return p[RECIP_SHIFT +: SPEED_W];
  endfunction

  // inverse cordic gain in Q30, worked out at elaboration
  function automatic logic [63:0] inv_gain(input int steps);
    logic [63:0] k2;
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] kq;
    logic [63:0] rem;
    logic [63:0] q;
    k2 = 64'd1 << Q30;
    for (int i = 0; i < 60; i++) begin
      if (i < steps && 2 * i <= Q30)
        k2 = (k2 * ((64'd1 << Q30) + (64'd1 << (Q30 - 2 * i)))) >> Q30;
    end
    n = k2 << Q30;
    r = '0;
    b = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (b > n) b = b >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    kq = (r == 0) ? 64'd1 : r;
    rem = '0;
    q = '0;
    for (int j = 60; j >= 0; j--) begin
      rem = (rem << 1) | ((j == 60) ? 64'd1 : 64'd0);
      if (rem >= kq) begin
        rem = rem - kq;
        q = q | (64'd1 << j);
      end
    end
    return q;
  endfunction

endpackage

FILE: rtl/holonomic_goto_pose_drive.sv
// Holonomic goto-pose drive: each pose item (target and current pose) gives one item of
// four wheel speeds, the travel and turn band codes and an arrived flag. Items pass a
// three-stage front pipeline that forms the errors and picks the bands, wait in a
// two-entry queue, and are then worked by the back end one at a time. The back end runs
// a 17-step square root of the squared distance followed by an 8-step serial divider
// for the proportional travel speed, with the CORDIC direction and its rotation running
// alongside. A finished result sits in the output register while the next item
// is already being worked. Registers are written through cfg_we/cfg_index/cfg_wdata and
// may only change while no item is in flight.
module holonomic_goto_pose_drive #(
  parameter int CORDIC_STEPS        = hgpd_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRACTION_BITS = hgpd_pkg::ANGLE_FRACTION_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [hgpd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [hgpd_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [hgpd_pkg::POS_W-1:0]     in_target_x,
  input  logic signed [hgpd_pkg::POS_W-1:0]     in_target_y,
  input  logic signed [hgpd_pkg::POS_W-1:0]     in_target_heading,
  input  logic signed [hgpd_pkg::POS_W-1:0]     in_current_x,
  input  logic signed [hgpd_pkg::POS_W-1:0]     in_current_y,
  input  logic signed [hgpd_pkg::POS_W-1:0]     in_current_heading,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [hgpd_pkg::WHEEL_W-1:0]   out_wheel_a,
  output logic signed [hgpd_pkg::WHEEL_W-1:0]   out_wheel_b,
  output logic signed [hgpd_pkg::WHEEL_W-1:0]   out_wheel_c,
  output logic signed [hgpd_pkg::WHEEL_W-1:0]   out_wheel_d,
  output logic [1:0]                            out_distance_band,
  output logic [1:0]                            out_turn_band,
  output logic                                  out_arrived
);

  hgpd_pkg::cfg_t       cfg_r;
  hgpd_pkg::fifo_stat_t q_stat;
  hgpd_pkg::item_t      push_item, head_item;
  logic                 push, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_speed       <= 8'd100;
      cfg_r.far_distance    <= 16'd1200;
      cfg_r.near_distance   <= 16'd170;
      cfg_r.stop_distance   <= 16'd80;
      cfg_r.fast_turn_error <= 16'd4915;
      cfg_r.slow_turn_error <= 16'd1434;
      cfg_r.stop_turn_error <= 16'd287;
    end else if (cfg_we) begin
      case (hgpd_pkg::reg_idx_t'(cfg_index))
        hgpd_pkg::REG_MAX_SPEED:       cfg_r.max_speed       <= cfg_wdata[7:0];
        hgpd_pkg::REG_FAR_DISTANCE:    cfg_r.far_distance    <= cfg_wdata;
        hgpd_pkg::REG_NEAR_DISTANCE:   cfg_r.near_distance   <= cfg_wdata;
        hgpd_pkg::REG_STOP_DISTANCE:   cfg_r.stop_distance   <= cfg_wdata;
        hgpd_pkg::REG_FAST_TURN_ERROR: cfg_r.fast_turn_error <= cfg_wdata;
        hgpd_pkg::REG_SLOW_TURN_ERROR: cfg_r.slow_turn_error <= cfg_wdata;
        hgpd_pkg::REG_STOP_TURN_ERROR: cfg_r.stop_turn_error <= cfg_wdata;
        default: ;
      endcase
    end
  end

  hgpd_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_target_x        (in_target_x),
    .in_target_y        (in_target_y),
    .in_target_heading  (in_target_heading),
    .in_current_x       (in_current_x),
    .in_current_y       (in_current_y),
    .in_current_heading (in_current_heading),
    .q_stat             (q_stat),
    .push               (push),
    .push_item          (push_item)
  );

  hgpd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .stat      (q_stat)
  );

  hgpd_back #(
    .CORDIC_STEPS        (CORDIC_STEPS),
    .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_stat            (q_stat),
    .item              (head_item),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_wheel_a       (out_wheel_a),
    .out_wheel_b       (out_wheel_b),
    .out_wheel_c       (out_wheel_c),
    .out_wheel_d       (out_wheel_d),
    .out_distance_band (out_distance_band),
    .out_turn_band     (out_turn_band),
    .out_arrived       (out_arrived)
  );

endmodule

FILE: rtl/hgpd_fifo.sv
// two-entry item queue between the classifying front and the arithmetic back
module hgpd_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  hgpd_pkg::item_t      push_item,
  input  logic                 pop,
  output hgpd_pkg::item_t      head_item,
  output hgpd_pkg::fifo_stat_t stat
);

  localparam int PTR_W = $clog2(hgpd_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(hgpd_pkg::QUEUE_DEPTH + 1);

  hgpd_pkg::item_t mem_r [hgpd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign stat.full  = (count_r == CNT_W'(hgpd_pkg::QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(hgpd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(hgpd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

FILE: rtl/hgpd_front.sv
// front pipeline: takes pose items, forms errors and squares, picks the speed bands
module hgpd_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  hgpd_pkg::cfg_t                        cfg,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [hgpd_pkg::POS_W-1:0]     in_target_x,
  input  logic signed [hgpd_pkg::POS_W-1:0]     in_target_y,
  input  logic signed [hgpd_pkg::POS_W-1:0]     in_target_heading,
  input  logic signed [hgpd_pkg::POS_W-1:0]     in_current_x,
  input  logic signed [hgpd_pkg::POS_W-1:0]     in_current_y,
  input  logic signed [hgpd_pkg::POS_W-1:0]     in_current_heading,
  input  hgpd_pkg::fifo_stat_t                  q_stat,
  output logic                                  push,
  output hgpd_pkg::item_t                       push_item
);

  localparam int DW = hgpd_pkg::DIFF_W;

  function automatic logic [hgpd_pkg::TNUM_W-1:0] TNUM_W_CAST(
    input logic [hgpd_pkg::DIST_W-1:0] a,
    input logic [9:0]                  b
  );
    return hgpd_pkg::TNUM_W'(a) * hgpd_pkg::TNUM_W'(b);
  endfunction

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  // stage 1: differences
  logic signed [DW-1:0] dx1_r, dy1_r, dh1_r;
  // stage 2: squares, turn numerator, turn band
  logic signed [DW-1:0]            dx2_r, dy2_r;
  logic [hgpd_pkg::SQ_W-1:0]       dxsq_r, dysq_r;
  logic [hgpd_pkg::TNUM_W-1:0]     tnum2_r;
  hgpd_pkg::band_t                 tband2_r;
  // squared distance thresholds
  logic [hgpd_pkg::SQ_W-1:0]       far_sq_r, near_sq_r, stop_sq_r;
  // stage 3: queue entry
  hgpd_pkg::item_t                 item3_r;

  logic signed [2*DW-1:0]          dxsq_full, dysq_full;
  logic [9:0]                      mx3;
  logic signed [DW:0]              dh_ext;
  hgpd_pkg::band_t                 tband_nxt;
  hgpd_pkg::band_t                 dband_nxt;
  logic [hgpd_pkg::SUM_W-1:0]      sum_sq;
  logic [hgpd_pkg::TNUM_W-1:0]     tnum_nxt;

  assign rdy3     = !v3_r || !q_stat.full;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;
  assign push      = v3_r && !q_stat.full;
  assign push_item = item3_r;

  assign dxsq_full = dx1_r * dx1_r;
  assign dysq_full = dy1_r * dy1_r;
  assign mx3       = {2'b00, cfg.max_speed} + {1'b0, cfg.max_speed, 1'b0};
  assign tnum_nxt  = TNUM_W_CAST(dh1_r[hgpd_pkg::DIST_W-1:0], mx3);
  assign dh_ext    = {dh1_r[DW-1], dh1_r};
  assign sum_sq    = {1'b0, dxsq_r} + {1'b0, dysq_r};

  // heading error bands, negative errors never pass a threshold
  always_comb begin
    if (dh_ext > $signed({2'b00, cfg.fast_turn_error}))
      tband_nxt = hgpd_pkg::BAND_FULL;
    else if (dh_ext > $signed({2'b00, cfg.slow_turn_error}))
      tband_nxt = hgpd_pkg::BAND_PROP;
    else if (dh_ext > $signed({2'b00, cfg.stop_turn_error}))
      tband_nxt = hgpd_pkg::BAND_CREEP;
    else
      tband_nxt = hgpd_pkg::BAND_STOP;
  end

  always_comb begin
    if (sum_sq > {1'b0, far_sq_r})
      dband_nxt = hgpd_pkg::BAND_FULL;
    else if (sum_sq > {1'b0, near_sq_r})
      dband_nxt = hgpd_pkg::BAND_PROP;
    else if (sum_sq > {1'b0, stop_sq_r})
      dband_nxt = hgpd_pkg::BAND_CREEP;
    else
      dband_nxt = hgpd_pkg::BAND_STOP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    far_sq_r  <= hgpd_pkg::SQ_W'(cfg.far_distance) * hgpd_pkg::SQ_W'(cfg.far_distance);
    near_sq_r <= hgpd_pkg::SQ_W'(cfg.near_distance) * hgpd_pkg::SQ_W'(cfg.near_distance);
    stop_sq_r <= hgpd_pkg::SQ_W'(cfg.stop_distance) * hgpd_pkg::SQ_W'(cfg.stop_distance);
    if (rdy1 && in_valid) begin
      dx1_r <= DW'(in_target_x) - DW'(in_current_x);
      dy1_r <= DW'(in_target_y) - DW'(in_current_y);
      dh1_r <= DW'(in_target_heading) - DW'(in_current_heading);
    end
    if (rdy2 && v1_r) begin
      dx2_r    <= dx1_r;
      dy2_r    <= dy1_r;
      dxsq_r   <= dxsq_full[hgpd_pkg::SQ_W-1:0];
      dysq_r   <= dysq_full[hgpd_pkg::SQ_W-1:0];
      tnum2_r  <= tnum_nxt;
      tband2_r <= tband_nxt;
    end
    if (rdy3 && v2_r) begin
      item3_r.dx       <= dx2_r;
      item3_r.dy       <= dy2_r;
      item3_r.sum_sq   <= sum_sq;
      item3_r.turn_num <= tnum2_r;
      item3_r.dband    <= dband_nxt;
      item3_r.tband    <= tband2_r;
    end
  end

endmodule

FILE: rtl/hgpd_back.sv
// back end: cordic direction, square root, serial dividers and wheel mixing
module hgpd_back #(
  parameter int CORDIC_STEPS        = hgpd_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRACTION_BITS = hgpd_pkg::ANGLE_FRACTION_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  hgpd_pkg::cfg_t                        cfg,
  input  hgpd_pkg::fifo_stat_t                  q_stat,
  input  hgpd_pkg::item_t                       item,
  output logic                                  pop,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [hgpd_pkg::WHEEL_W-1:0]   out_wheel_a,
  output logic signed [hgpd_pkg::WHEEL_W-1:0]   out_wheel_b,
  output logic signed [hgpd_pkg::WHEEL_W-1:0]   out_wheel_c,
  output logic signed [hgpd_pkg::WHEEL_W-1:0]   out_wheel_d,
  output logic [1:0]                            out_distance_band,
  output logic [1:0]                            out_turn_band,
  output logic                                  out_arrived
);

  localparam int F         = ANGLE_FRACTION_BITS;
  localparam int XW        = hgpd_pkg::CORDIC_W;
  localparam int UW        = hgpd_pkg::VEC_W;
  localparam int DVW       = hgpd_pkg::DIV_W;
  localparam int SQW       = F + 2;
  localparam int MW        = F + 12;
  localparam int PW        = XW + 16;
  localparam int FW        = PW + hgpd_pkg::INV_SQRT2_SPLIT + 1;
  localparam int RND_SH    = 2 * hgpd_pkg::Q30 - F - 1;
  localparam int SDIV_BEG  = hgpd_pkg::SQRT_STEPS + 1;
  localparam int SDIV_END  = SDIV_BEG + hgpd_pkg::DIV_STEPS;
  localparam int LAST      = (CORDIC_STEPS + 2 > SDIV_END) ? CORDIC_STEPS + 2 : SDIV_END;
  localparam int CW        = $clog2(LAST + 1);
  localparam logic [63:0] INV_GAIN = hgpd_pkg::inv_gain(CORDIC_STEPS);
  localparam logic signed [PW-1:0] INV_SQRT2_HI_S = PW'(hgpd_pkg::INV_SQRT2_HI);
  localparam logic signed [PW-1:0] INV_SQRT2_LO_S = PW'(hgpd_pkg::INV_SQRT2_LO);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t          state_r;
  logic [CW-1:0]   cnt_r;
  logic            out_valid_r;

  logic signed [XW-1:0]           x_r, y_r;
  logic signed [UW-1:0]           u_r, v_r;
  logic                           flip_r;
  logic [hgpd_pkg::RAD_W-1:0]     rad_r;
  logic [hgpd_pkg::REM_W-1:0]     rem_r;
  logic [hgpd_pkg::ROOT_W-1:0]    root_r;
  logic [DVW-1:0]                 ns_r, nt_r;
  logic [hgpd_pkg::SPEED_W-1:0]   qs_r, qt_r;
  hgpd_pkg::band_t                dband_r, tband_r;
  logic signed [PW-1:0]           phc_r, plc_r, phs_r, pls_r;
  logic signed [SQW-1:0]          sq_r, cq_r;
  logic signed [hgpd_pkg::WHEEL_W-1:0] wa_r, wb_r, wc_r, wd_r;
  hgpd_pkg::band_t                odb_r, otb_r;
  logic                           oarr_r;

  logic at_last, out_free, fire;
  logic cordic_en, sqrt_en, tdiv_en, sload, sdiv_en, rot_a, rot_b;

  assign at_last   = (cnt_r == CW'(LAST));
  assign out_free  = !out_valid_r || !out_stall;
  assign fire      = (state_r == ST_RUN) && at_last && out_free;
  assign pop       = !q_stat.empty && ((state_r == ST_IDLE) || fire);
  assign cordic_en = (state_r == ST_RUN) && (cnt_r < CW'(CORDIC_STEPS));
  assign sqrt_en   = (state_r == ST_RUN) && (cnt_r < CW'(hgpd_pkg::SQRT_STEPS));
  assign tdiv_en   = (state_r == ST_RUN) && (cnt_r < CW'(hgpd_pkg::DIV_STEPS));
  assign sload     = (state_r == ST_RUN) && (cnt_r == CW'(hgpd_pkg::SQRT_STEPS));
  assign sdiv_en   = (state_r == ST_RUN) && (cnt_r >= CW'(SDIV_BEG)) &&
                     (cnt_r < CW'(SDIV_END));
  assign rot_a     = (state_r == ST_RUN) && (cnt_r == CW'(CORDIC_STEPS));
  assign rot_b     = (state_r == ST_RUN) && (cnt_r == CW'(CORDIC_STEPS + 1));

  // load values of a new item
  logic signed [XW-1:0] x0, y0;
  assign x0 = XW'(item.dx) <<< hgpd_pkg::PRE_SHIFT;
  assign y0 = XW'(item.dy) <<< hgpd_pkg::PRE_SHIFT;

  // one cordic micro-rotation, shifts round toward minus infinity
  logic signed [XW-1:0] xs, ys, x_nxt, y_nxt;
  logic signed [UW-1:0] us, vs, u_nxt, v_nxt;
  always_comb begin
    xs = x_r >>> cnt_r;
    ys = y_r >>> cnt_r;
    us = u_r >>> cnt_r;
    vs = v_r >>> cnt_r;
    if (y_r > 0) begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      u_nxt = u_r - vs;
      v_nxt = v_r + us;
    end else begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      u_nxt = u_r + vs;
      v_nxt = v_r - us;
    end
  end

  // one digit of the square root
  logic [hgpd_pkg::REM_W:0]      rem_sh, trial;
  logic [hgpd_pkg::REM_W-1:0]    rem_nxt;
  logic [hgpd_pkg::ROOT_W-1:0]   root_nxt;
  always_comb begin
    rem_sh = {rem_r[hgpd_pkg::REM_W-2:0], rad_r[hgpd_pkg::RAD_W-1 -: 2]};
    trial  = {2'b00, root_r, 2'b01};
    if (rem_sh >= trial) begin
      rem_nxt  = hgpd_pkg::REM_W'(rem_sh - trial);
      root_nxt = {root_r[hgpd_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = hgpd_pkg::REM_W'(rem_sh);
      root_nxt = {root_r[hgpd_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  // restoring division steps; quotient stays below 256 in the proportional bands
  logic [hgpd_pkg::DEN_W-1:0] den_s, den_t;
  logic [hgpd_pkg::DIV_BW-1:0] bs, bt;
  logic [DVW:0]   dsh_s, dsh_t;
  logic [DVW-1:0] ns_nxt, nt_nxt;
  logic [hgpd_pkg::SPEED_W-1:0] qs_nxt, qt_nxt;
  logic [CW-1:0]  bs_full;
  always_comb begin
    den_s   = {cfg.far_distance, 3'b000} + {3'b000, cfg.far_distance, 1'b0};
    den_t   = {cfg.fast_turn_error, 3'b000} + {3'b000, cfg.fast_turn_error, 1'b0};
    bt      = hgpd_pkg::DIV_BW'(hgpd_pkg::DIV_STEPS - 1) - cnt_r[hgpd_pkg::DIV_BW-1:0];
    bs_full = CW'(SDIV_END - 1) - cnt_r;
    bs      = bs_full[hgpd_pkg::DIV_BW-1:0];
    dsh_s   = (DVW + 1)'(den_s) << bs;
    dsh_t   = (DVW + 1)'(den_t) << bt;
    ns_nxt  = ns_r;
    qs_nxt  = qs_r;
    nt_nxt  = nt_r;
    qt_nxt  = qt_r;
    if ({1'b0, ns_r} >= dsh_s) begin
      ns_nxt     = ns_r - dsh_s[DVW-1:0];
      qs_nxt[bs] = 1'b1;
    end
    if ({1'b0, nt_r} >= dsh_t) begin
      nt_nxt     = nt_r - dsh_t[DVW-1:0];
      qt_nxt[bt] = 1'b1;
    end
  end

  // rotation by a quarter of pi, undoing the half-turn pre-flip first
  logic signed [UW-1:0] ue, ve;
  logic signed [XW-1:0] dm, dp;
  logic signed [FW-1:0] fc, fs;
  logic signed [FW-1:0] rc, rs;
  always_comb begin
    ue = flip_r ? -u_r : u_r;
    ve = flip_r ? -v_r : v_r;
    dm = XW'(ue) - XW'(ve);
    dp = XW'(ue) + XW'(ve);
    fc = (FW'(phc_r) <<< hgpd_pkg::INV_SQRT2_SPLIT) + FW'(plc_r);
    fs = (FW'(phs_r) <<< hgpd_pkg::INV_SQRT2_SPLIT) + FW'(pls_r);
    rc = (fc + (FW'(1) <<< RND_SH)) >>> (RND_SH + 1);
    rs = (fs + (FW'(1) <<< RND_SH)) >>> (RND_SH + 1);
  end

  // band speeds and wheel mix
  logic [hgpd_pkg::SPEED_W-1:0] speed, turn;
  logic [11:0] mx8, mx15, mx3;
  logic signed [MW-1:0] ps_s, ps_c, tw;
  logic signed [MW-1:0] sum_a, sum_b, sum_c, sum_d;

  function automatic logic signed [hgpd_pkg::WHEEL_W-1:0] trunc0(
    input logic signed [MW-1:0] val
  );
    logic signed [MW-1:0] t;
    t = val >>> F;
    if (val[MW-1] && (val[F-1:0] != '0)) t = t + 1'b1;
    return t[hgpd_pkg::WHEEL_W-1:0];
  endfunction

  always_comb begin
    mx8  = {1'b0, cfg.max_speed, 3'b000};
    mx15 = {cfg.max_speed, 4'b0000} - {4'b0000, cfg.max_speed};
    mx3  = {4'b0000, cfg.max_speed} + {3'b000, cfg.max_speed, 1'b0};
    case (dband_r)
      hgpd_pkg::BAND_FULL:  speed = hgpd_pkg::div10(mx8);
      hgpd_pkg::BAND_PROP:  speed = qs_r;
      hgpd_pkg::BAND_CREEP: speed = hgpd_pkg::div100(mx15);
      default:              speed = '0;
    endcase
    case (tband_r)
      hgpd_pkg::BAND_FULL:  turn = hgpd_pkg::div10(mx3);
      hgpd_pkg::BAND_PROP:  turn = qt_r;
      hgpd_pkg::BAND_CREEP: turn = hgpd_pkg::div100(mx15);
      default:              turn = '0;
    endcase
    ps_s  = MW'($signed({1'b0, speed})) * MW'(sq_r);
    ps_c  = MW'($signed({1'b0, speed})) * MW'(cq_r);
    tw    = MW'($signed({1'b0, turn})) <<< F;
    sum_a = tw - ps_s;
    sum_b = tw + ps_c;
    sum_c = tw + ps_s;
    sum_d = tw - ps_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (out_valid_r && out_stall) || fire;
      case (state_r)
        ST_IDLE: begin
          if (pop) begin
            state_r <= ST_RUN;
            cnt_r   <= '0;
          end
        end
        ST_RUN: begin
          if (!at_last) begin
            cnt_r <= cnt_r + 1'b1;
          end else if (fire) begin
            cnt_r <= '0;
            if (!pop) state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      flip_r  <= item.dx[hgpd_pkg::DIFF_W-1];
      x_r     <= item.dx[hgpd_pkg::DIFF_W-1] ? -x0 : x0;
      y_r     <= item.dx[hgpd_pkg::DIFF_W-1] ? -y0 : y0;
      u_r     <= $signed(INV_GAIN[UW-1:0]);
      v_r     <= '0;
      rad_r   <= {1'b0, item.sum_sq};
      rem_r   <= '0;
      root_r  <= '0;
      nt_r    <= DVW'(item.turn_num);
      qt_r    <= '0;
      qs_r    <= '0;
      dband_r <= item.dband;
      tband_r <= item.tband;
    end else begin
      if (cordic_en) begin
        x_r <= x_nxt;
        y_r <= y_nxt;
        u_r <= u_nxt;
        v_r <= v_nxt;
      end
      if (sqrt_en) begin
        rad_r  <= rad_r << 2;
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
      end
      if (tdiv_en) begin
        nt_r <= nt_nxt;
        qt_r <= qt_nxt;
      end
      if (sload) ns_r <= DVW'(root_r) * DVW'(mx8);
      if (sdiv_en) begin
        ns_r <= ns_nxt;
        qs_r <= qs_nxt;
      end
    end
    if (rot_a) begin
      phc_r <= dm * INV_SQRT2_HI_S;
      plc_r <= dm * INV_SQRT2_LO_S;
      phs_r <= dp * INV_SQRT2_HI_S;
      pls_r <= dp * INV_SQRT2_LO_S;
    end
    if (rot_b) begin
      cq_r <= rc[SQW-1:0];
      sq_r <= rs[SQW-1:0];
    end
    if (fire) begin
      wa_r   <= trunc0(sum_a);
      wb_r   <= trunc0(sum_b);
      wc_r   <= trunc0(sum_c);
      wd_r   <= trunc0(sum_d);
      odb_r  <= dband_r;
      otb_r  <= tband_r;
      oarr_r <= (dband_r == hgpd_pkg::BAND_STOP) && (tband_r == hgpd_pkg::BAND_STOP);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_wheel_a       = wa_r;
  assign out_wheel_b       = wb_r;
  assign out_wheel_c       = wc_r;
  assign out_wheel_d       = wd_r;
  assign out_distance_band = odb_r;
  assign out_turn_band     = otb_r;
  assign out_arrived       = oarr_r;

endmodule

FILE: rtl/hgpd_checker.sv
// port-level checks on the result channel of the goto-pose drive, bound to the top level
module hgpd_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [hgpd_pkg::WHEEL_W-1:0]  out_wheel_a,
  input logic signed [hgpd_pkg::WHEEL_W-1:0]  out_wheel_b,
  input logic signed [hgpd_pkg::WHEEL_W-1:0]  out_wheel_c,
  input logic signed [hgpd_pkg::WHEEL_W-1:0]  out_wheel_d,
  input logic [1:0]                           out_distance_band,
  input logic [1:0]                           out_turn_band,
  input logic                                 out_arrived
);

  // a stalled item stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_wheel_a) && $stable(out_wheel_b) &&
      $stable(out_wheel_c) && $stable(out_wheel_d) && $stable(out_distance_band) &&
      $stable(out_turn_band) && $stable(out_arrived))
    else $error("result item changed while stalled");

  a_arrived: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_arrived == ((out_distance_band == hgpd_pkg::BAND_STOP) &&
                                  (out_turn_band == hgpd_pkg::BAND_STOP)))
    else $error("arrived flag disagrees with the bands");

  // no travel leaves only the turn term on every wheel
  a_no_travel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_distance_band == hgpd_pkg::BAND_STOP |->
      out_wheel_a == out_wheel_b && out_wheel_b == out_wheel_c && out_wheel_c == out_wheel_d)
    else $error("wheels differ with travel stopped");

  a_still: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_arrived |->
      out_wheel_a == '0 && out_wheel_b == '0 && out_wheel_c == '0 && out_wheel_d == '0)
    else $error("wheels moving after arrival");

endmodule

bind holonomic_goto_pose_drive hgpd_checker u_hgpd_checker (.*);

FILE: test/holonomic_goto_pose_drive_test.sv
// self-checking testbench of the holonomic goto-pose drive with its own wheel speed predictor
`timescale 1ns / 100ps

module holonomic_goto_pose_drive_test;
  import hgpd_pkg::*;

  localparam int F = ANGLE_FRACTION_BITS_DEF;
  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam longint CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 60;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  typedef struct {
    logic signed [POS_W-1:0] tx, ty, th, cx, cy, ch;
  } pose_t;

  typedef struct {
    logic [WHEEL_W-1:0] wa, wb, wc, wd;
    band_t dband, tband;
    logic arrived;
  } wheels_t;

  class drive_scoreboard;
    wheels_t pending[$];
    int errors;
    longint unsigned inv_k;
    longint unsigned top_speed, far_d, near_d, stop_d, fast_t, slow_t, stop_t;

    function new();
      longint unsigned k2;
      errors = 0;
      top_speed = 100; far_d = 1200; near_d = 170; stop_d = 80;
      fast_t = 4915; slow_t = 1434; stop_t = 287;
      k2 = 64'd1 << 30;
      for (int i = 0; i < STEPS; i++)
        if (2 * i <= 30) k2 = (k2 * ((64'd1 << 30) + (64'd1 << (30 - 2 * i)))) >> 30;
      inv_k = root(k2 << 30);
      if (inv_k == 0) inv_k = 1;
      inv_k = (64'd1 << 60) / inv_k;
    endfunction

    function longint unsigned root(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_MAX_SPEED:       top_speed = d[7:0];
        REG_FAR_DISTANCE:    far_d = d;
        REG_NEAR_DISTANCE:   near_d = d;
        REG_STOP_DISTANCE:   stop_d = d;
        REG_FAST_TURN_ERROR: fast_t = d;
        REG_SLOW_TURN_ERROR: slow_t = d;
        REG_STOP_TURN_ERROR: stop_t = d;
        default: ;
      endcase
    endfunction

    // sine and cosine of the travel direction plus a quarter of pi
    function void heading_vec(longint dx, longint dy, output longint sq, output longint cq);
      longint x, y, u, v, xs, ys, us, vs, c, s;
      bit flip;
      x = dx * 16384;
      y = dy * 16384;
      u = longint'(inv_k);
      v = 0;
      flip = x < 0;
      if (flip) begin
        x = -x;
        y = -y;
      end
      for (int i = 0; i < STEPS; i++) begin
        xs = x >>> i; ys = y >>> i; us = u >>> i; vs = v >>> i;
        if (y > 0) begin
          x += ys; y -= xs; u -= vs; v += us;
        end else begin
          x -= ys; y += xs; u += vs; v -= us;
        end
      end
      if (flip) begin
        u = -u;
        v = -v;
      end
      c = ((u - v) * 64'sd759250125) >>> 30;
      s = ((u + v) * 64'sd759250125) >>> 30;
      cq = (c + (64'sd1 <<< (29 - F))) >>> (30 - F);
      sq = (s + (64'sd1 <<< (29 - F))) >>> (30 - F);
    endfunction

    function logic [WHEEL_W-1:0] trunc_wheel(longint v);
      longint r;
      r = (v >= 0) ? (v >>> F) : -((-v) >>> F);
      return r[WHEEL_W-1:0];
    endfunction

    function void note_pose(pose_t p);
      longint dx, dy, dh, speed, turn, sq, cq, tw;
      longint unsigned s, mag;
      wheels_t w;
      dx = longint'(p.tx) - longint'(p.cx);
      dy = longint'(p.ty) - longint'(p.cy);
      dh = longint'(p.th) - longint'(p.ch);
      s = dx * dx + dy * dy;
      mag = root(s);
      if (s > far_d * far_d) begin
        w.dband = BAND_FULL; speed = 8 * top_speed / 10;
      end else if (s > near_d * near_d) begin
        w.dband = BAND_PROP;
        speed = far_d != 0 ? mag * 8 * top_speed / (10 * far_d) : 0;
      end else if (s > stop_d * stop_d) begin
        w.dband = BAND_CREEP; speed = 15 * top_speed / 100;
      end else begin
        w.dband = BAND_STOP; speed = 0;
      end
      // negative heading error never beats a threshold
      if (dh > longint'(fast_t)) begin
        w.tband = BAND_FULL; turn = 3 * top_speed / 10;
      end else if (dh > longint'(slow_t)) begin
        w.tband = BAND_PROP;
        turn = fast_t != 0 ? longint'($unsigned(dh) * 3 * top_speed / (10 * fast_t)) : 0;
      end else if (dh > longint'(stop_t)) begin
        w.tband = BAND_CREEP; turn = 15 * top_speed / 100;
      end else begin
        w.tband = BAND_STOP; turn = 0;
      end
      heading_vec(dx, dy, sq, cq);
      tw = turn * (64'sd1 <<< F);
      w.wa = trunc_wheel(-speed * sq + tw);
      w.wb = trunc_wheel(speed * cq + tw);
      w.wc = trunc_wheel(speed * sq + tw);
      w.wd = trunc_wheel(-speed * cq + tw);
      w.arrived = (w.dband == BAND_STOP) && (w.tband == BAND_STOP);
      pending.push_back(w);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_wheels(wheels_t got);
      wheels_t e;
      if (pending.size() == 0) begin
        report("result item with nothing expected");
      end else begin
        e = pending.pop_front();
        if (got.wa !== e.wa) report($sformatf("wheel_a %0h exp %0h", got.wa, e.wa));
        if (got.wb !== e.wb) report($sformatf("wheel_b %0h exp %0h", got.wb, e.wb));
        if (got.wc !== e.wc) report($sformatf("wheel_c %0h exp %0h", got.wc, e.wc));
        if (got.wd !== e.wd) report($sformatf("wheel_d %0h exp %0h", got.wd, e.wd));
        if (got.dband !== e.dband) report($sformatf("distance band %0d exp %0d", got.dband, e.dband));
        if (got.tband !== e.tband) report($sformatf("turn band %0d exp %0d", got.tband, e.tband));
        if (got.arrived !== e.arrived) report($sformatf("arrived %0b exp %0b", got.arrived, e.arrived));
      end
    endtask
  endclass

  logic clk, rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid, in_stall, out_valid;
  logic out_stall = 1'b0;
  logic signed [POS_W-1:0] in_tx, in_ty, in_th, in_cx, in_cy, in_ch;
  logic signed [WHEEL_W-1:0] out_wa, out_wb, out_wc, out_wd;
  logic [1:0] out_dband, out_tband;
  logic out_arrived;

  drive_scoreboard sb = new();
  longint cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;

  holonomic_goto_pose_drive i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_target_x(in_tx), .in_target_y(in_ty), .in_target_heading(in_th),
    .in_current_x(in_cx), .in_current_y(in_cy), .in_current_heading(in_ch),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_wheel_a(out_wa), .out_wheel_b(out_wb), .out_wheel_c(out_wc), .out_wheel_d(out_wd),
    .out_distance_band(out_dband), .out_turn_band(out_tband), .out_arrived(out_arrived)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    wheels_t got;
    pose_t p;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("holonomic_goto_pose_drive_test NOT OK");
      $finish;
    end
    if (rst_n && in_valid && !in_stall) begin
      p.tx = in_tx; p.ty = in_ty; p.th = in_th;
      p.cx = in_cx; p.cy = in_cy; p.ch = in_ch;
      sb.note_pose(p);
    end
    if (rst_n && out_valid && !out_stall) begin
      got.wa = out_wa; got.wb = out_wb; got.wc = out_wc; got.wd = out_wd;
      got.dband = band_t'(out_dband); got.tband = band_t'(out_tband);
      got.arrived = out_arrived;
      sb.check_wheels(got);
    end
    // receiver stall pattern switches at random between none, coin-flip and mostly stalled
    if (cycles % 200 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task send_pose(pose_t p);
    if (burst_left == 0) burst_left = $urandom_range(1, 12);
    in_valid <= 1'b1;
    in_tx <= p.tx; in_ty <= p.ty; in_th <= p.th;
    in_cx <= p.cx; in_cy <= p.cy; in_ch <= p.ch;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left == 0) begin
      int gap;
      gap = $urandom_range(0, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task drain;
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    sb.write_reg(idx, d);
    @(posedge clk);
  endtask

  task set_all(logic [15:0] ms, logic [15:0] fd, logic [15:0] nd, logic [15:0] sd,
               logic [15:0] ft, logic [15:0] st, logic [15:0] zt);
    drain();
    write_reg(REG_MAX_SPEED, ms);
    write_reg(REG_FAR_DISTANCE, fd);
    write_reg(REG_NEAR_DISTANCE, nd);
    write_reg(REG_STOP_DISTANCE, sd);
    write_reg(REG_FAST_TURN_ERROR, ft);
    write_reg(REG_SLOW_TURN_ERROR, st);
    write_reg(REG_STOP_TURN_ERROR, zt);
    write_reg(CFG_IDX_UNUSED, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic pose_t mk(int tx, int ty, int th, int cx, int cy, int ch);
    pose_t p;
    p.tx = 16'(tx); p.ty = 16'(ty); p.th = 16'(th);
    p.cx = 16'(cx); p.cy = 16'(cy); p.ch = 16'(ch);
    return p;
  endfunction

  // offset spread around the band edges of a threshold
  function automatic int near_offset(longint unsigned edge_val);
    int lim;
    lim = (edge_val * 2 + 100 > 65535) ? 65535 : int'(edge_val * 2 + 100);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  task random_poses(int n);
    pose_t p;
    int kind;
    repeat (n) begin
      kind = $urandom_range(0, 9);
      p.tx = 16'($urandom); p.ty = 16'($urandom); p.th = 16'($urandom);
      if (kind < 7) begin
        p.cx = p.tx - 16'(near_offset(sb.far_d));
        p.cy = p.ty - 16'(near_offset(kind < 4 ? sb.near_d : sb.far_d));
        p.ch = p.th - 16'(near_offset(kind < 4 ? sb.slow_t : sb.fast_t));
      end else if (kind == 7) begin
        p.cx = p.tx; p.cy = p.ty; p.ch = p.th - 16'($urandom_range(0, 600));
      end else begin
        p.cx = 16'($urandom); p.cy = 16'($urandom); p.ch = 16'($urandom);
      end
      send_pose(p);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    in_valid = 1'b0;
    in_tx = '0; in_ty = '0; in_th = '0; in_cx = '0; in_cy = '0; in_ch = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero error, negative heading error, extremes, each band
    send_pose(mk(0, 0, 0, 0, 0, 0));
    send_pose(mk(5, -7, -3000, 5, -7, 3000));
    send_pose(mk(32767, 32767, 32767, -32768, -32768, -32768));
    send_pose(mk(-32768, -32768, -32768, 32767, 32767, 32767));
    send_pose(mk(32767, -32768, 0, -32768, 32767, 0));
    send_pose(mk(-32768, 0, 0, 32767, 0, 0));
    send_pose(mk(0, 1500, 6000, 0, 0, 0));
    send_pose(mk(600, 0, 3000, 0, 0, 0));
    send_pose(mk(0, -600, 2000, 0, 0, 0));
    send_pose(mk(-100, 0, 500, 0, 0, 0));
    send_pose(mk(0, 100, 100, 0, 0, 0));
    send_pose(mk(1200, 0, 4915, 0, 0, 0));
    send_pose(mk(170, 0, 1434, 0, 0, 0));
    send_pose(mk(80, 0, 287, 0, 0, 0));
    send_pose(mk(81, 0, 288, 0, 0, 0));
    send_pose(mk(-300, -300, 4916, 0, 0, 0));
    random_poses(120);

    // every register at its top, max speed written wider than its width
    set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pose(mk(32767, 32767, 32767, -32768, -32768, -32768));
    random_poses(80);
    // all zero: nonzero distance or positive heading error goes straight to the full band
    set_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_pose(mk(0, 0, 0, 0, 0, 0));
    random_poses(60);
    set_all(16'd255, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    random_poses(60);
    // bands out of order
    set_all(16'd255, 16'd100, 16'd900, 16'd3000, 16'd200, 16'd2000, 16'd8000);
    random_poses(100);
    set_all(16'd200, 16'd2000, 16'd500, 16'd40, 16'd8000, 16'd2000, 16'd100);
    random_poses(100);
    repeat (2) begin
      set_all(16'($urandom), 16'($urandom_range(0, 20000)), 16'($urandom_range(0, 3000)),
              16'($urandom_range(0, 500)), 16'($urandom), 16'($urandom_range(0, 8000)),
              16'($urandom_range(0, 1000)));
      random_poses(80);
    end

    drain();
    if (sb.errors == 0) begin
      $display("holonomic_goto_pose_drive_test OK");
    end else begin
      $display("holonomic_goto_pose_drive_test NOT OK");
    end
    $finish;
  end

endmodule
